@@ design/isr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

    // style selection codes
    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_DISABLED = 2'd1,
        MODE_SELECTED = 2'd2
    } mode_t;

    // register indexes on the config port
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STYLE_MODE      = 8'd0,
        REG_WINDOW_RED      = 8'd1,
        REG_WINDOW_GREEN    = 8'd2,
        REG_WINDOW_BLUE     = 8'd3,
        REG_HIGHLIGHT_RED   = 8'd4,
        REG_HIGHLIGHT_GREEN = 8'd5,
        REG_HIGHLIGHT_BLUE  = 8'd6,
        REG_TINT_ALPHA      = 8'd7
    } reg_idx_t;

    localparam logic [7:0] TINT_ALPHA_RESET = 8'd77;

    // x / 255 for any 16-bit x: (x * 32897) >> 23
    localparam logic [15:0] DIV255_MUL = 16'd32897;
    // x / 3 for any 8-bit x: (x * 171) >> 9
    localparam logic [7:0]  DIV3_MUL   = 8'd171;

    // configuration seen by the datapath; channel 0 blue, 1 green, 2 red
    typedef struct packed {
        logic [1:0]      style_mode;
        logic [2:0][7:0] window;
        logic [2:0][7:0] hp;          // highlight * alpha / 255
        logic [7:0]      tint_alpha;
        logic [7:0]      ramp_base;   // 130 - adjusted intensity / 3
    } cfg_t;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [31:0] p;
        p = {16'd0, x} * {16'd0, DIV255_MUL};
        return p[30:23];
    endfunction

    function automatic logic [6:0] div3(input logic [7:0] x);
        logic [15:0] p;
        p = {8'd0, x} * {8'd0, DIV3_MUL};
        return p[15:9];
    endfunction

endpackage

`default_nettype wire

@@ design/isr_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module isr_cfg
    import isr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    output cfg_t                      cfg
);

    logic [1:0]      style_mode_reg;
    logic [2:0][7:0] window_reg;
    logic [2:0][7:0] highlight_reg;
    logic [7:0]      tint_alpha_reg;

    // derived values, three register levels deep
    logic [15:0]       wsum_reg;
    logic              sat_reg;
    logic [2:0][15:0]  hcs_reg;
    logic [7:0]        inten_reg;
    logic              sat2_reg;
    logic [2:0][7:0]   hp_reg;
    logic [7:0]        base_reg;

    logic [15:0]       wsum_next;
    logic              sat_next;
    logic [2:0][15:0]  hcs_next;
    logic [7:0]        inten_next;
    logic [2:0][7:0]   hp_next;
    logic [7:0]        base_next;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_mode_reg <= MODE_PASS;
            window_reg     <= '0;
            highlight_reg  <= '0;
            tint_alpha_reg <= TINT_ALPHA_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STYLE_MODE:      style_mode_reg   <= cfg_data[1:0];
                REG_WINDOW_RED:      window_reg[2]    <= cfg_data;
                REG_WINDOW_GREEN:    window_reg[1]    <= cfg_data;
                REG_WINDOW_BLUE:     window_reg[0]    <= cfg_data;
                REG_HIGHLIGHT_RED:   highlight_reg[2] <= cfg_data;
                REG_HIGHLIGHT_GREEN: highlight_reg[1] <= cfg_data;
                REG_HIGHLIGHT_BLUE:  highlight_reg[0] <= cfg_data;
                REG_TINT_ALPHA:      tint_alpha_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // level 1: weighted window sum, saturation test, highlight * alpha
    always_comb
    begin
        logic [8:0] r, g, b;
        r = {1'b0, window_reg[2]};
        g = {1'b0, window_reg[1]};
        b = {1'b0, window_reg[0]};
        wsum_next = {8'd0, window_reg[2]} * 16'd77
                  + {8'd0, window_reg[1]} * 16'd150
                  + {8'd0, window_reg[0]} * 16'd28;
        // one channel beats both others by more than 191
        sat_next = (r > g + 9'd191 && r > b + 9'd191) ||
                   (g > r + 9'd191 && g > b + 9'd191) ||
                   (b > r + 9'd191 && b > g + 9'd191);
        for (int k = 0; k < 3; k++)
        begin
            hcs_next[k] = {8'd0, highlight_reg[k]} * {8'd0, tint_alpha_reg};
        end
    end

    // level 2: divisions by 255
    always_comb
    begin
        inten_next = div255(wsum_reg);
        for (int k = 0; k < 3; k++)
        begin
            hp_next[k] = div255(hcs_reg[k]);
        end
    end

    // level 3: adjust intensity, ramp offset 130 - I/3 (truncated toward zero)
    always_comb
    begin
        logic [8:0] boost;
        logic [7:0] mag;
        logic       neg;
        logic [6:0] q;
        boost = {1'b0, inten_reg} + 9'd91;
        neg   = 1'b0;
        priority if (sat2_reg)
        begin
            mag = boost[8] ? 8'd255 : boost[7:0];
        end
        else if (inten_reg <= 8'd128)
        begin
            if (inten_reg < 8'd51)
            begin
                neg = 1'b1;
                mag = 8'd51 - inten_reg;
            end
            else
            begin
                mag = inten_reg - 8'd51;
            end
        end
        else
        begin
            mag = inten_reg;
        end
        q = div3(mag);
        base_next = neg ? 8'd130 + {1'b0, q} : 8'd130 - {1'b0, q};
    end

    always_ff @(posedge clk)
    begin
        wsum_reg  <= wsum_next;
        sat_reg   <= sat_next;
        hcs_reg   <= hcs_next;
        inten_reg <= inten_next;
        sat2_reg  <= sat_reg;
        hp_reg    <= hp_next;
        base_reg  <= base_next;
    end

    assign cfg.style_mode = style_mode_reg;
    assign cfg.window     = window_reg;
    assign cfg.hp         = hp_reg;
    assign cfg.tint_alpha = tint_alpha_reg;
    assign cfg.ramp_base  = base_reg;

endmodule

`default_nettype wire

@@ design/isr_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module isr_pipe
    import isr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] in_pixel,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_pixel
);

    logic [5:1] valid_reg;
    logic       adv;

    logic [31:0]       s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic [7:0]        s1_gray_reg;
    logic [2:0][15:0]  s1_dcs_reg;
    logic [6:0]        s2_gray3_reg, s3_gray3_reg;
    logic [2:0][7:0]   s2_dq_reg, s3_dq_reg;
    logic [2:0][15:0]  s3_hpa_reg;
    logic [7:0]        s4_ci_reg;
    logic [2:0][7:0]   s4_tint_reg;
    logic [31:0]       out_pixel_reg;

    logic [7:0]        s1_gray_next;
    logic [2:0][15:0]  s1_dcs_next;
    logic [6:0]        s2_gray3_next;
    logic [2:0][7:0]   s2_dq_next;
    logic [2:0][15:0]  s3_hpa_next;
    logic [7:0]        s4_ci_next;
    logic [2:0][7:0]   s4_tint_next;
    logic [31:0]       out_pixel_next;

    // whole pipe holds while the output word is stalled
    assign adv      = !(valid_reg[5] && out_stall);
    assign in_stall = !adv;

    function automatic logic [7:0] ramp(input logic [7:0] c, input logic [7:0] ci);
        logic [15:0] p;
        logic [8:0]  s;
        p = {8'd0, c} * {8'd0, ci[6:0], 1'b0};
        s = {1'b0, c} + {1'b0, ci[6:0], 1'b0};
        if (!ci[7])
            return p[15:8];
        return s[8] ? 8'd255 : s[7:0];
    endfunction

    // stage 1: gray sum, destination * (255 - alpha)
    always_comb
    begin
        logic [12:0] gsum;
        logic [7:0]  nsa;
        gsum = {5'd0, in_pixel[23:16]} * 13'd11
             + {1'b0, in_pixel[15:8], 4'd0}
             + {5'd0, in_pixel[7:0]} * 13'd5;
        s1_gray_next = gsum[12:5];
        nsa = 8'd255 - cfg.tint_alpha;
        for (int k = 0; k < 3; k++)
        begin
            s1_dcs_next[k] = {8'd0, in_pixel[8*k +: 8]} * {8'd0, nsa};
        end
    end

    // stage 2: gray / 3, destination term / 255
    always_comb
    begin
        s2_gray3_next = div3(s1_gray_reg);
        for (int k = 0; k < 3; k++)
        begin
            s2_dq_next[k] = div255(s1_dcs_reg[k]);
        end
    end

    // stage 3: premultiplied highlight * destination alpha
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_hpa_next[k] = {8'd0, cfg.hp[k]} * {8'd0, s2_pix_reg[31:24]};
        end
    end

    // stage 4: ramp index, tint sum with clamp
    always_comb
    begin
        logic [8:0] cis;
        logic [8:0] t;
        cis = {2'd0, s3_gray3_reg} + {1'b0, cfg.ramp_base};
        s4_ci_next = cis[8] ? 8'd255 : cis[7:0];
        for (int k = 0; k < 3; k++)
        begin
            t = {1'b0, div255(s3_hpa_reg[k])} + {1'b0, s3_dq_reg[k]};
            s4_tint_next[k] = t[8] ? 8'd255 : t[7:0];
        end
    end

    // stage 5: ramp lookup and mode select
    always_comb
    begin
        unique case (cfg.style_mode)
            MODE_DISABLED:
            begin
                out_pixel_next = {s4_pix_reg[31:24],
                                  ramp(cfg.window[2], s4_ci_reg),
                                  ramp(cfg.window[1], s4_ci_reg),
                                  ramp(cfg.window[0], s4_ci_reg)};
            end
            MODE_SELECTED:
            begin
                out_pixel_next = {s4_pix_reg[31:24], s4_tint_reg[2],
                                  s4_tint_reg[1], s4_tint_reg[0]};
            end
            default:
            begin
                out_pixel_next = s4_pix_reg;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[4:1], in_valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg    <= in_pixel;
            s1_gray_reg   <= s1_gray_next;
            s1_dcs_reg    <= s1_dcs_next;
            s2_pix_reg    <= s1_pix_reg;
            s2_gray3_reg  <= s2_gray3_next;
            s2_dq_reg     <= s2_dq_next;
            s3_pix_reg    <= s2_pix_reg;
            s3_gray3_reg  <= s2_gray3_reg;
            s3_dq_reg     <= s2_dq_reg;
            s3_hpa_reg    <= s3_hpa_next;
            s4_pix_reg    <= s3_pix_reg;
            s4_ci_reg     <= s4_ci_next;
            s4_tint_reg   <= s4_tint_next;
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_pixel = out_pixel_reg;

endmodule

`default_nettype wire

@@ design/icon_state_pixel_restyle_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Icon pixel restyler: one ARGB32 word in, one word out, one word per cycle
// sustained through a five-stage pipeline while out_stall is low; the single
// output register stalls the whole pipe at once. Style 0 (and the unused
// code 3) passes the pixel through, style 1 maps a straight-alpha pixel
// onto a black/window/white gray ramp, style 2 blends the highlight color
// source-atop onto a premultiplied pixel; alpha is always kept. Registers
// are written on the config port (index 0..7, other indexes ignored;
// cfg_ready is always high). Derived config terms settle in registers
// before the pipeline stages that use them, so an item may follow a write
// on the next cycle. Write config only while the pipeline is empty.
module icon_state_pixel_restyle_top
    import isr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [31:0]          in_pixel,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [31:0]               out_pixel
);

    cfg_t cfg;

    isr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    isr_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  (in_pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel)
    );

endmodule

`default_nettype wire
